### rtl/core/ffa_pkg.sv
// Shared constants and types for the first-fit block allocator.
package ffa_pkg;

    localparam int HEAP_BYTES_DEF = 32768;
    localparam int OWNER_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_COUNT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

endpackage

### rtl/core/first_fit_block_allocator_top.sv
// First-fit heap allocator: header walker over a granule-indexed header RAM.
//
// Usage: one request word enters on the input channel (i_in_valid/o_in_ready)
// and exactly one result word leaves on the output channel
// (o_out_valid/i_out_ready). Operations: allocate (first fit, 8-byte rounding,
// split when the remainder holds a header plus a granule), free (owner and
// exact payload match, merge with free neighbors) and count of small free blocks.
// Block headers live in one RAM with one entry per 8-byte granule, holding
// taken mark, length in granules and owner.
// Per request the walker reads each block header visited (address, then
// registered read data); an allocate then writes back the taken header, a
// free reads the following header if there is one, merges and writes back,
// and the result is then posted. The registered read port of the header RAM
// sets the walker's pace.
// Requests are taken one at a time; a new request is taken while the previous
// result still sits in the output register.
// Reset: synchronous, active low. After reset, state S_INIT writes the single
// free block that covers the whole heap; o_in_ready stays low during it.
// Output stall: a finished result waits until the output register is free,
// and the block takes no new word until then.
module first_fit_block_allocator_top
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_request_size,
    input  logic [14:0] i_block_address,
    input  logic [7:0]  i_task_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [14:0] o_payload_offset,
    output logic [12:0] o_fragment_count
);

    localparam int G  = HEAP_BYTES / 8;
    localparam int GW = $clog2(G);
    localparam int DW = 1 + GW + OWNER_BITS;
    localparam int BW = (GW + 4 > 16) ? GW + 4 : 16;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_RD, S_EV, S_TAKE, S_RDN, S_EVN, S_MRG
    } t_state;
    t_state r_state;
    logic   r_done;

    t_op                   r_op;
    logic [15:0]           r_size;
    logic [14:0]           r_addr;
    logic [7:0]            r_task;
    logic [GW:0]           r_pos;
    logic [GW-1:0]         r_cur;
    logic [GW-1:0]         r_prev_pos;
    logic [GW-1:0]         r_prev_len;
    logic                  r_prev_free;
    logic [GW-1:0]         r_len;
    logic [OWNER_BITS-1:0] r_own;
    logic [12:0]           r_cnt;
    logic                  r_res_status;
    logic [14:0]           r_res_off;
    logic [12:0]           r_res_cnt;
    logic                  r_ovalid;
    logic                  r_ostatus;
    logic [14:0]           r_ooff;
    logic [12:0]           r_ocnt;

    logic                  w_we;
    logic [GW-1:0]         w_waddr;
    logic [DW-1:0]         w_wdata;
    logic [GW-1:0]         w_raddr;
    logic [DW-1:0]         w_rdata;
    logic                  w_rd_taken;
    logic [GW-1:0]         w_rd_len;
    logic [OWNER_BITS-1:0] w_rd_own;
    logic [OWNER_BITS-1:0] w_task_own;
    logic [15:0]           w_task16;
    logic [GW:0]           w_nxt;
    logic                  w_end;
    logic [BW-1:0]         w_need;
    logic [BW-1:0]         w_len_b;
    logic                  w_fit;
    logic                  w_split;
    logic                  w_small;
    logic [BW-1:0]         w_pb;
    logic [BW-1:0]         w_addr_b;
    logic                  w_accept;
    logic                  w_post;

    ffa_ram #(.WIDTH(DW), .DEPTH(G), .AW(GW)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // split the header read back from the RAM
    assign w_rd_taken = w_rdata[DW-1];
    assign w_rd_len   = w_rdata[OWNER_BITS +: GW];
    assign w_rd_own   = w_rdata[OWNER_BITS-1:0];
    assign w_task16   = {8'd0, r_task};
    assign w_task_own = w_task16[OWNER_BITS-1:0];

    // chain step and compares in byte or granule units
    assign w_nxt    = r_pos + (GW+1)'(w_rd_len) + 1'b1;
    assign w_end    = (w_nxt >= (GW+1)'(G));
    assign w_need   = BW'((17'(r_size) + 17'd7) >> 3);
    assign w_len_b  = BW'(w_rd_len);
    assign w_fit    = !w_rd_taken && (w_len_b >= w_need);
    assign w_split  = w_len_b > (w_need + BW'(1));
    assign w_small  = !w_rd_taken &&
                      (BW'({(GW+1)'(w_rd_len) + 1'b1, 3'b000}) < BW'(r_size));
    assign w_pb     = BW'({r_pos + 1'b1, 3'b000});
    assign w_addr_b = BW'(r_addr);

    assign w_accept = i_in_valid && o_in_ready;
    assign w_post   = r_done && (!r_ovalid || i_out_ready);

    // drive the RAM ports from the sequencer state
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = r_pos[GW-1:0];
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = {1'b0, GW'(G - 1), {OWNER_BITS{1'b0}}};
            end
            S_EV: begin
                if (r_op == OP_ALLOC && w_fit && w_split) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[GW-1:0] + GW'(w_need) + 1'b1;
                    w_wdata = {1'b0, GW'(w_len_b - w_need - BW'(1)),
                               {OWNER_BITS{1'b0}}};
                end
            end
            S_TAKE: begin
                w_we    = 1'b1;
                w_waddr = r_pos[GW-1:0];
                w_wdata = {1'b1, r_len, w_task_own};
            end
            S_MRG: begin
                w_we = 1'b1;
                if (r_prev_free) begin
                    w_waddr = r_prev_pos;
                    w_wdata = {1'b0, r_prev_len + r_len + 1'b1, {OWNER_BITS{1'b0}}};
                end else begin
                    w_waddr = r_cur;
                    w_wdata = {1'b0, r_len, r_own};
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_done;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_post) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= r_res_status;
                r_ooff    <= r_res_off;
                r_ocnt    <= r_res_cnt;
                r_done    <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= t_op'(i_operation);
                        r_size       <= i_request_size;
                        r_addr       <= i_block_address;
                        r_task       <= i_task_id;
                        r_pos        <= '0;
                        r_cnt        <= '0;
                        r_prev_free  <= 1'b0;
                        r_res_status <= ST_FAIL;
                        r_res_off    <= '0;
                        r_res_cnt    <= '0;
                        if (t_op'(i_operation) == OP_NONE ||
                            (t_op'(i_operation) == OP_ALLOC && i_request_size == 16'd0)) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    case (r_op)
                        OP_ALLOC: begin
                            if (w_fit) begin
                                r_len        <= w_split ? GW'(w_need) : w_rd_len;
                                r_res_status <= ST_OK;
                                r_res_off    <= 15'(w_pb);
                                r_state      <= S_TAKE;
                            end else if (w_end) begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_pos   <= w_nxt;
                                r_state <= S_RD;
                            end
                        end
                        OP_FREE: begin
                            if (w_pb < w_addr_b) begin
                                r_prev_pos  <= r_pos[GW-1:0];
                                r_prev_len  <= w_rd_len;
                                r_prev_free <= !w_rd_taken;
                                if (w_end) begin
                                    r_done  <= 1'b1;
                                    r_state <= S_IDLE;
                                end else begin
                                    r_pos   <= w_nxt;
                                    r_state <= S_RD;
                                end
                            end else if (w_pb == w_addr_b && w_rd_taken &&
                                         w_rd_own == w_task_own) begin
                                r_len        <= w_rd_len;
                                r_own        <= w_rd_own;
                                r_cur        <= r_pos[GW-1:0];
                                r_res_status <= ST_OK;
                                r_pos        <= w_nxt;
                                r_state      <= w_end ? S_MRG : S_RDN;
                            end else begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            // count small free blocks
                            if (w_small) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                            if (w_end) begin
                                r_res_status <= ST_OK;
                                r_res_cnt    <= w_small ? r_cnt + 1'b1 : r_cnt;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_pos   <= w_nxt;
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_TAKE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_RDN: begin
                    r_state <= S_EVN;
                end
                S_EVN: begin
                    if (!w_rd_taken) begin
                        r_len <= r_len + w_rd_len + 1'b1;
                    end
                    r_state <= S_MRG;
                end
                S_MRG: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_payload_offset = r_ooff;
    assign o_fragment_count = r_ocnt;

    // no header write while waiting for a request
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("header write while idle");

    // an accepted word always starts a walk or posts a result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RD || r_done))
        else $error("accepted word dropped");

    // the walker only evaluates headers inside the heap
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV || r_state == S_EVN) |-> (r_pos < (GW+1)'(G)))
        else $error("header read past heap end");

endmodule

### rtl/core/ffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### bench/testbench.sv
// Self-checking testbench for the first-fit block allocator.
module testbench
    import ffa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP = 32768;
    localparam int GRAN = HEAP / 8;
    localparam int HDR = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = OP_NONE;
    logic [15:0] i_request_size = '0;
    logic [14:0] i_block_address = '0;
    logic [7:0]  i_task_id = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_status;
    logic [14:0] o_payload_offset;
    logic [12:0] o_fragment_count;

    typedef struct packed {
        logic        status;
        logic [14:0] offset;
        logic [12:0] frag;
    } t_answer;

    // Shadow heap headers, indexed by granule
    int unsigned hp_len[GRAN];
    bit          hp_taken[GRAN];
    logic [7:0]  hp_owner[GRAN];

    t_answer answers_due[$];
    int      error_count = 0;
    bit      quiet_tail = 1'b0;

    // Live allocations: payload offset and owner
    int unsigned live_addr[$];
    logic [7:0]  live_task[$];

    first_fit_block_allocator_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic t_answer heap_alloc(int unsigned size, logic [7:0] tid);
        int unsigned need, pos, g, r;
        t_answer a;
        need = (size + 7) & ~32'd7;
        pos = 0;
        a = '{status: ST_FAIL, offset: '0, frag: '0};
        if (size == 0) return a;
        while (pos < HEAP) begin
            g = pos / 8;
            if (!hp_taken[g] && hp_len[g] >= need) begin
                if (hp_len[g] > need + HDR) begin
                    r = (pos + HDR + need) / 8;
                    hp_len[r] = hp_len[g] - need - HDR;
                    hp_taken[r] = 1'b0;
                    hp_len[g] = need;
                end
                hp_taken[g] = 1'b1;
                hp_owner[g] = tid;
                a.status = ST_OK;
                a.offset = 15'(pos + HDR);
                return a;
            end
            pos = pos + HDR + hp_len[g];
        end
        return a;
    endfunction

    function automatic t_answer heap_free(int unsigned addr, logic [7:0] tid);
        int unsigned pos, prev, g, nx;
        bit has_prev;
        t_answer a;
        pos = 0;
        prev = 0;
        has_prev = 1'b0;
        a = '{status: ST_FAIL, offset: '0, frag: '0};
        while (pos < HEAP && pos + HDR < addr) begin
            prev = pos;
            has_prev = 1'b1;
            pos = pos + HDR + hp_len[pos / 8];
        end
        if (pos >= HEAP || pos + HDR != addr) return a;
        g = pos / 8;
        if (!hp_taken[g] || hp_owner[g] != tid) return a;
        hp_taken[g] = 1'b0;
        nx = pos + HDR + hp_len[g];
        if (nx < HEAP && !hp_taken[nx / 8]) hp_len[g] += hp_len[nx / 8] + HDR;
        if (has_prev && !hp_taken[prev / 8]) hp_len[prev / 8] += hp_len[g] + HDR;
        a.status = ST_OK;
        return a;
    endfunction

    function automatic t_answer heap_count(int unsigned lim);
        int unsigned pos, g, n;
        t_answer a;
        pos = 0;
        n = 0;
        while (pos < HEAP) begin
            g = pos / 8;
            if (!hp_taken[g] && hp_len[g] + HDR < lim) n++;
            pos = pos + HDR + hp_len[g];
        end
        a = '{status: ST_OK, offset: '0, frag: 13'(n)};
        return a;
    endfunction

    function automatic t_answer heap_step(t_op op, logic [15:0] sz, logic [14:0] ad,
                                          logic [7:0] tid);
        t_answer a;
        a = '{status: ST_FAIL, offset: '0, frag: '0};
        case (op)
            OP_ALLOC: a = heap_alloc(sz, tid);
            OP_FREE:  a = heap_free(ad, tid);
            OP_COUNT: a = heap_count(sz);
            default:  a = '{status: ST_FAIL, offset: '0, frag: '0};
        endcase
        return a;
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("ERROR %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Send one word, predicting its result at acceptance; valid stays high
    // into the next word unless an idle burst or a drain drops it
    task automatic send_word(t_op op, logic [15:0] sz, logic [14:0] ad, logic [7:0] tid);
        t_answer a;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_request_size <= sz;
        i_block_address <= ad;
        i_task_id <= tid;
        do @(posedge i_clk); while (!o_in_ready);
        a = heap_step(op, sz, ad, tid);
        answers_due.push_back(a);
        if (op == OP_ALLOC && a.status == ST_OK) begin
            live_addr.push_back(a.offset);
            live_task.push_back(tid);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                w = answers_due.pop_front();
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_payload_offset !== w.offset)
                    report("payload_offset", o_payload_offset, w.offset);
                if (o_fragment_count !== w.frag)
                    report("fragment_count", o_fragment_count, w.frag);
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (quiet_tail || $urandom_range(0, 4) != 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(posedge i_clk);
            end
        end
    end

    task automatic free_live(int idx, bit wrong_owner);
        logic [7:0] tid;
        tid = wrong_owner ? live_task[idx] ^ 8'(1 << $urandom_range(0, 7)) : live_task[idx];
        send_word(OP_FREE, 16'($urandom), 15'(live_addr[idx]), tid);
        if (!wrong_owner) begin
            live_addr.delete(idx);
            live_task.delete(idx);
        end
    endtask

    task automatic test_directed();
        send_word(OP_COUNT, 16'hFFFF, '0, '0);
        send_word(OP_ALLOC, 16'd0, '0, 8'd1);
        send_word(OP_ALLOC, 16'd32768, '0, 8'd1);
        send_word(OP_ALLOC, 16'd1, 15'h7FFF, 8'd0);
        send_word(OP_ALLOC, 16'd8, '0, 8'hFF);
        send_word(OP_ALLOC, 16'd17, '0, 8'hA5);
        send_word(OP_ALLOC, 16'd24, '0, 8'h5A);
        send_word(OP_FREE, '0, 15'd0, 8'd0);
        send_word(OP_FREE, '0, 15'd4, 8'd0);
        send_word(OP_FREE, '0, 15'h7FFF, 8'd0);
        send_word(OP_FREE, '0, 15'd9, 8'd0);
        send_word(OP_FREE, '0, 15'd16, 8'hFE);
        send_word(OP_NONE, 16'hFFFF, 15'h7FFF, 8'hFF);
        // free middle, then first, double free, then the rest
        free_live(2, 1'b0);
        free_live(0, 1'b0);
        send_word(OP_FREE, '0, 15'd8, 8'd0);
        send_word(OP_COUNT, 16'd40, '0, '0);
        send_word(OP_COUNT, 16'd0, '0, '0);
        free_live(0, 1'b0);
        free_live(0, 1'b0);
        // whole-heap exact-fit allocate, allocate on the full heap, then release
        send_word(OP_ALLOC, 16'd32760, '0, 8'd7);
        send_word(OP_ALLOC, 16'd8, '0, 8'd7);
        free_live(0, 1'b0);
        send_word(OP_COUNT, 16'hFFFF, '0, '0);
    endtask

    task automatic test_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (i == n / 2) drain();
            if (k < 4)
                send_word(OP_ALLOC, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                          : 16'($urandom_range(1, 600)), 15'($urandom), 8'($urandom));
            else if (k < 7 && live_addr.size() != 0)
                free_live($urandom_range(0, live_addr.size() - 1), 1'b0);
            else if (k == 7 && live_addr.size() != 0)
                free_live($urandom_range(0, live_addr.size() - 1), 1'b1);
            else if (k == 8)
                send_word(OP_COUNT, 16'($urandom_range(0, 2000)), 15'($urandom), 8'($urandom));
            else
                send_word(t_op'($urandom_range(1, 3)), 16'($urandom), 15'($urandom),
                          8'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < GRAN; i++) begin
            hp_len[i] = 0;
            hp_taken[i] = 1'b0;
            hp_owner[i] = '0;
        end
        hp_len[0] = HEAP - HDR;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(100);
        quiet_tail = 1'b1;
        test_random(20);
        drain();
        repeat (2 * GRAN + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("first_fit_block_allocator_top: match");
        else
            $display("first_fit_block_allocator_top: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #10ms;
        $display("first_fit_block_allocator_top: mismatch");
        $finish;
    end
endmodule
